// ===== rtl/http_start_line_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// HTTP start line parser assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HTTP_START_LINE_PARSER_UNIT_ASSERT_SVH
`define HTTP_START_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define HSLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define HSLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hslp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP start line parser package
// Phase encoding, byte constants and the result record of the parser.
// ----------------------------------------------------------------------------
package hslp_pkg;

    // Phases of the start line automaton.
    typedef enum logic [4:0] {
        PH_START, PH_METHOD, PH_TFIRST, PH_TARGET,
        PH_VH, PH_VT1, PH_VT2, PH_VP, PH_VSL,
        PH_VMAJ, PH_VDOT, PH_VMIN, PH_VEND,
        PH_S1, PH_S2, PH_S3, PH_SSP, PH_TEXT, PH_LF, PH_DONE
    } t_phase;

    // Byte codes that the automaton tests for.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Prefix tracker codes: all four letters of "HTTP" seen, or mismatch.
    localparam logic [2:0] PREFIX_FULL = 3'd4;
    localparam logic [2:0] PREFIX_MISS = 3'd7;

    // Largest legal three-digit status value.
    localparam logic [9:0] STATUS_MAX = 10'd999;

    // Character classes of one byte.
    typedef struct packed {
        logic digit;
        logic tchar;
        logic target;
        logic text;
    } t_char_class;

    // One parse result.
    typedef struct packed {
        logic        line_ok;
        logic        is_response;
        logic [3:0]  version_major;
        logic [3:0]  version_minor;
        logic [9:0]  status_code;
        logic [13:0] method_length;
        logic [12:0] target_offset;
        logic [13:0] target_length;
        logic [12:0] text_offset;
        logic [13:0] text_length;
    } t_result;

endpackage

// ===== rtl/hslp_if.sv =====
// ----------------------------------------------------------------------------
// HTTP start line parser channels
// Valid/ready channels for line bytes in and parse results out.
// ----------------------------------------------------------------------------

// Byte channel: one line byte per item, with a last-byte flag.
interface hslp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       final_byte;

    modport source (output valid, output line_byte, output final_byte, input ready);
    modport sink   (input valid, input line_byte, input final_byte, output ready);
endinterface

// Result channel: one parse result per item.
interface hslp_out_if;
    logic        valid;
    logic        ready;
    logic        line_ok;
    logic        is_response;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic [9:0]  status_code;
    logic [13:0] method_length;
    logic [12:0] target_offset;
    logic [13:0] target_length;
    logic [12:0] text_offset;
    logic [13:0] text_length;

    modport source (
        output valid, input ready,
        output line_ok, output is_response, output version_major, output version_minor,
        output status_code, output method_length, output target_offset,
        output target_length, output text_offset, output text_length
    );
    modport sink (
        input valid, output ready,
        input line_ok, input is_response, input version_major, input version_minor,
        input status_code, input method_length, input target_offset,
        input target_length, input text_offset, input text_length
    );
endinterface

// ===== rtl/hslp_char_class.sv =====
// ----------------------------------------------------------------------------
// HTTP start line parser character classifier
// Sorts one byte into the digit, token, target and text classes.
// ----------------------------------------------------------------------------
module hslp_char_class (
    input  logic [7:0]           i_byte,
    output hslp_pkg::t_char_class o_class
);

    logic w_digit;
    logic w_alnum;
    logic w_tchar;
    logic w_target;
    logic w_text;

    // Letters and digits belong to both the token and the target classes.
    assign w_digit = (i_byte >= hslp_pkg::CH_ZERO) && (i_byte <= hslp_pkg::CH_NINE);
    assign w_alnum = w_digit
        || ((i_byte >= 8'h41) && (i_byte <= 8'h5A))
        || ((i_byte >= 8'h61) && (i_byte <= 8'h7A));

    // Token punctuation allowed in a method.
    always_comb begin
        case (i_byte) inside
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: begin
                w_tchar = 1'b1;
            end
            default: begin
                w_tchar = w_alnum;
            end
        endcase
    end

    // Punctuation allowed in a request target.
    always_comb begin
        case (i_byte) inside
            8'h21, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
            8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3D,
            8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h5F, 8'h7E: begin
                w_target = 1'b1;
            end
            default: begin
                w_target = w_alnum;
            end
        endcase
    end

    // Reason text takes tab, space and every printable or high byte.
    assign w_text = (i_byte == hslp_pkg::CH_TAB)
        || ((i_byte >= hslp_pkg::CH_SP) && (i_byte != hslp_pkg::CH_DEL));

    // Gather the classes into one record.
    always_comb begin
        o_class.digit  = w_digit;
        o_class.tchar  = w_tchar;
        o_class.target = w_target;
        o_class.text   = w_text;
    end

endmodule

// ===== rtl/hslp_parser_core.sv =====
// ----------------------------------------------------------------------------
// HTTP start line parser core
// Byte automaton with its position counters; forms the result of each line.
// ----------------------------------------------------------------------------
module hslp_parser_core #(
    parameter int unsigned MAX_LINE = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_line_byte,
    input  logic              i_final_byte,
    output hslp_pkg::t_result o_result
);

    localparam int unsigned POS_W = $clog2(MAX_LINE + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);

    hslp_pkg::t_char_class w_class;

    hslp_pkg::t_phase r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_prefix, n_prefix;
    logic             r_failed, n_failed;
    logic             r_kind, n_kind;
    logic [3:0]       r_major, n_major;
    logic [3:0]       r_minor, n_minor;
    logic [9:0]       r_status, n_status;
    logic [POS_W-1:0] r_first_len, n_first_len;
    logic [POS_W-1:0] r_second_start, n_second_start;
    logic [POS_W-1:0] r_second_len, n_second_len;

    logic             w_pos_ok;
    logic [3:0]       w_digit;

    // Letters of the "HTTP" prefix in order.
    function automatic logic [7:0] http_word_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = hslp_pkg::CH_H;
            2'd3:    ch = hslp_pkg::CH_P;
            default: ch = hslp_pkg::CH_T;
        endcase
        return ch;
    endfunction

    // Count matching prefix letters; any miss parks the tracker.
    function automatic logic [2:0] track_prefix(input logic [2:0] prefix, input logic [7:0] b);
        logic [2:0] nxt;
        if ((prefix < hslp_pkg::PREFIX_FULL) && (b == http_word_char(prefix[1:0]))) begin
            nxt = prefix + 3'd1;
        end else begin
            nxt = hslp_pkg::PREFIX_MISS;
        end
        return nxt;
    endfunction

    hslp_char_class u_char_class (
        .i_byte  (i_line_byte),
        .o_class (w_class)
    );

    assign w_pos_ok = r_pos < POS_LIMIT;
    assign w_digit  = 4'(i_line_byte - hslp_pkg::CH_ZERO);

    // Next state of the automaton for the byte in hand.
    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_prefix       = r_prefix;
        n_failed       = r_failed;
        n_kind         = r_kind;
        n_major        = r_major;
        n_minor        = r_minor;
        n_status       = r_status;
        n_first_len    = r_first_len;
        n_second_start = r_second_start;
        n_second_len   = r_second_len;
        if (i_step) begin
            if (!w_pos_ok) begin
                n_failed = 1'b1;
            end else if (!r_failed) begin
                unique case (r_phase)
                    hslp_pkg::PH_START: begin
                        if (!w_class.tchar) begin
                            n_failed = 1'b1;
                        end else begin
                            n_prefix    = track_prefix(r_prefix, i_line_byte);
                            n_first_len = POS_W'(1);
                            n_phase     = hslp_pkg::PH_METHOD;
                        end
                    end
                    hslp_pkg::PH_METHOD: begin
                        if (i_line_byte == hslp_pkg::CH_SP) begin
                            n_phase = hslp_pkg::PH_TFIRST;
                        end else if ((i_line_byte == hslp_pkg::CH_SLASH)
                                     && (r_prefix == hslp_pkg::PREFIX_FULL)) begin
                            n_kind  = 1'b1;
                            n_phase = hslp_pkg::PH_VMAJ;
                        end else if (w_class.tchar) begin
                            n_prefix    = track_prefix(r_prefix, i_line_byte);
                            n_first_len = r_first_len + 1'b1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    hslp_pkg::PH_TFIRST: begin
                        if (!w_class.target) begin
                            n_failed = 1'b1;
                        end else begin
                            n_second_start = r_pos;
                            n_second_len   = POS_W'(1);
                            n_phase        = hslp_pkg::PH_TARGET;
                        end
                    end
                    hslp_pkg::PH_TARGET: begin
                        if (i_line_byte == hslp_pkg::CH_SP) begin
                            n_phase = hslp_pkg::PH_VH;
                        end else if (w_class.target) begin
                            n_second_len = r_second_len + 1'b1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    hslp_pkg::PH_VH: begin
                        if (i_line_byte == hslp_pkg::CH_H) n_phase = hslp_pkg::PH_VT1;
                        else n_failed = 1'b1;
                    end
                    hslp_pkg::PH_VT1: begin
                        if (i_line_byte == hslp_pkg::CH_T) n_phase = hslp_pkg::PH_VT2;
                        else n_failed = 1'b1;
                    end
                    hslp_pkg::PH_VT2: begin
                        if (i_line_byte == hslp_pkg::CH_T) n_phase = hslp_pkg::PH_VP;
                        else n_failed = 1'b1;
                    end
                    hslp_pkg::PH_VP: begin
                        if (i_line_byte == hslp_pkg::CH_P) n_phase = hslp_pkg::PH_VSL;
                        else n_failed = 1'b1;
                    end
                    hslp_pkg::PH_VSL: begin
                        if (i_line_byte == hslp_pkg::CH_SLASH) n_phase = hslp_pkg::PH_VMAJ;
                        else n_failed = 1'b1;
                    end
                    hslp_pkg::PH_VMAJ: begin
                        if (!w_class.digit) begin
                            n_failed = 1'b1;
                        end else begin
                            n_major = w_digit;
                            n_phase = hslp_pkg::PH_VDOT;
                        end
                    end
                    hslp_pkg::PH_VDOT: begin
                        if (i_line_byte == hslp_pkg::CH_DOT) n_phase = hslp_pkg::PH_VMIN;
                        else n_failed = 1'b1;
                    end
                    hslp_pkg::PH_VMIN: begin
                        if (!w_class.digit) begin
                            n_failed = 1'b1;
                        end else begin
                            n_minor = w_digit;
                            n_phase = hslp_pkg::PH_VEND;
                        end
                    end
                    hslp_pkg::PH_VEND: begin
                        // A status line continues with a space, a request ends here.
                        if (r_kind) begin
                            if (i_line_byte == hslp_pkg::CH_SP) n_phase = hslp_pkg::PH_S1;
                            else n_failed = 1'b1;
                        end else begin
                            if (i_line_byte == hslp_pkg::CH_CR) n_phase = hslp_pkg::PH_LF;
                            else n_failed = 1'b1;
                        end
                    end
                    hslp_pkg::PH_S1, hslp_pkg::PH_S2, hslp_pkg::PH_S3: begin
                        if (!w_class.digit) begin
                            n_failed = 1'b1;
                        end else begin
                            n_status = (r_status << 3) + (r_status << 1) + 10'(w_digit);
                            unique case (r_phase)
                                hslp_pkg::PH_S1: n_phase = hslp_pkg::PH_S2;
                                hslp_pkg::PH_S2: n_phase = hslp_pkg::PH_S3;
                                default:         n_phase = hslp_pkg::PH_SSP;
                            endcase
                        end
                    end
                    hslp_pkg::PH_SSP: begin
                        if (i_line_byte != hslp_pkg::CH_SP) begin
                            n_failed = 1'b1;
                        end else begin
                            n_second_start = r_pos + 1'b1;
                            n_second_len   = '0;
                            n_phase        = hslp_pkg::PH_TEXT;
                        end
                    end
                    hslp_pkg::PH_TEXT: begin
                        if (i_line_byte == hslp_pkg::CH_CR) begin
                            n_phase = hslp_pkg::PH_LF;
                        end else if (w_class.text) begin
                            n_second_len = r_second_len + 1'b1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    hslp_pkg::PH_LF: begin
                        if (i_line_byte == hslp_pkg::CH_LF) n_phase = hslp_pkg::PH_DONE;
                        else n_failed = 1'b1;
                    end
                    default: begin
                        // Anything after the closing line feed spoils the line.
                        n_failed = 1'b1;
                    end
                endcase
            end
            if (w_pos_ok) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // Result of the line as it stands after this byte; all zero when invalid.
    always_comb begin
        o_result = '0;
        if (!n_failed && (n_phase == hslp_pkg::PH_DONE)) begin
            o_result.line_ok       = 1'b1;
            o_result.is_response   = n_kind;
            o_result.version_major = n_major;
            o_result.version_minor = n_minor;
            if (n_kind) begin
                o_result.status_code = n_status;
                o_result.text_offset = 13'(n_second_start);
                o_result.text_length = 14'(n_second_len);
            end else begin
                o_result.method_length = 14'(n_first_len);
                o_result.target_offset = 13'(n_second_start);
                o_result.target_length = 14'(n_second_len);
            end
        end
    end

    // State registers; a final byte returns the automaton to start of line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_final_byte)) begin
            r_phase        <= hslp_pkg::PH_START;
            r_pos          <= '0;
            r_prefix       <= '0;
            r_failed       <= 1'b0;
            r_kind         <= 1'b0;
            r_major        <= '0;
            r_minor        <= '0;
            r_status       <= '0;
            r_first_len    <= '0;
            r_second_start <= '0;
            r_second_len   <= '0;
        end else begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_prefix       <= n_prefix;
            r_failed       <= n_failed;
            r_kind         <= n_kind;
            r_major        <= n_major;
            r_minor        <= n_minor;
            r_status       <= n_status;
            r_first_len    <= n_first_len;
            r_second_start <= n_second_start;
            r_second_len   <= n_second_len;
        end
    end

endmodule

// ===== rtl/http_start_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP start line parser
// Checks one HTTP request or status line, one byte per item, and reports
// its kind, version, status and field positions on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one byte of the start line per item, with final_byte set on
//   the last byte. Every byte but the last produces no result; the last byte
//   produces exactly one item on o_out and starts a fresh line.
//   A byte is registered in the input register on acceptance and then run
//   through the automaton; the result is loaded into the output register
//   when the final byte is processed. One byte is taken every cycle while no
//   final byte waits on a pending result, set by the input register and the
//   automaton update.
//   Lines longer than MAX_LINE bytes come out with line_ok low and all other
//   fields zero, as does any line that breaks the request or status form.
//   When o_out stalls, a pending result waits in the output register and
//   bytes keep flowing; only a further final byte waits until the pending
//   result is taken, which in turn holds i_in.ready low.
//   Reset puts the automaton at start of line and empties both registers.
// ----------------------------------------------------------------------------
`include "http_start_line_parser_unit_assert.svh"

module http_start_line_parser_unit #(
    parameter int unsigned MAX_LINE = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hslp_in_if.sink     i_in,
    hslp_out_if.source  o_out
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_final;
    logic              r_out_valid;
    hslp_pkg::t_result r_out;
    hslp_pkg::t_result w_result;
    logic              w_step;

    // A held byte moves on unless it closes a line and the result slot is full and not being taken.
    assign w_step     = r_in_valid && (!r_in_final || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.line_byte;
            r_in_final <= i_in.final_byte;
        end
    end

    hslp_parser_core #(
        .MAX_LINE (MAX_LINE)
    ) u_parser_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_line_byte  (r_in_byte),
        .i_final_byte (r_in_final),
        .o_result     (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_final) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.line_ok       = r_out.line_ok;
    assign o_out.is_response   = r_out.is_response;
    assign o_out.version_major = r_out.version_major;
    assign o_out.version_minor = r_out.version_minor;
    assign o_out.status_code   = r_out.status_code;
    assign o_out.method_length = r_out.method_length;
    assign o_out.target_offset = r_out.target_offset;
    assign o_out.target_length = r_out.target_length;
    assign o_out.text_offset   = r_out.text_offset;
    assign o_out.text_length   = r_out.text_length;

    // A closing byte is never processed over a result that is still waiting.
    `HSLP_ASSERT_IMP(a_no_overwrite, w_step && r_in_final, !r_out_valid || o_out.ready, "result overwritten")

    // A result shows up only right after a closing byte was processed.
    `HSLP_ASSERT_IMP(a_out_from_final, $rose(r_out_valid), $past(w_step && r_in_final), "result without final byte")

    // A rejected line carries nothing but zeros.
    `HSLP_ASSERT_IMP(a_bad_line_zero, r_out_valid && !r_out.line_ok, (r_out.is_response == 1'b0) && (r_out.status_code == '0) && (r_out.method_length == '0) && (r_out.target_length == '0) && (r_out.text_length == '0), "invalid line has fields")

    // A closing byte always leaves a result pending in the next cycle.
    `HSLP_ASSERT_NXT(a_final_gives_out, w_step && r_in_final, r_out_valid && (r_out.status_code <= hslp_pkg::STATUS_MAX), "final byte lost")

endmodule

// ===== verif/http_start_line_parser_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP start line parser unit test
// Streams request lines, status lines, damaged lines and raw noise into the
// parser one byte per item and checks every parse result against a byte-level
// model of the start line automaton kept in this bench. The byte channel and
// the result channel idle and stall at random in several pacing phases.
// ----------------------------------------------------------------------------
module http_start_line_parser_unit_test;

    localparam int LINE_LIMIT    = 8192;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 200;
    localparam int RANDOM_LINES  = 12;
    localparam int SEGMENT_LINES = 3;

    // Grave accent, a token character that is awkward inside a string.
    localparam logic [7:0] CH_GRAVE = 8'h60;

    // Pacing of the two channels.
    typedef enum logic [1:0] {
        PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH
    } t_pace;

    // One byte waiting to be sent, with its pacing and pressure marks.
    typedef struct {
        logic [7:0] data;
        logic       fin;
        t_pace      pace;
        logic       drain;
        logic       hold;
    } t_tx_item;

    string alnum_set    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string token_punct  = "!#$%&'*+-.^_|~";
    string target_punct = "+-.:/_~%!$&'()*,;=@[]?";

    logic i_clk;
    logic i_rst_n;

    hslp_in_if  in_ch ();
    hslp_out_if out_ch ();

    t_tx_item          bytes_to_send[$];
    hslp_pkg::t_result results_due[$];
    int                bytes_total;
    int                bytes_taken;
    int                mismatches;
    t_pace             tx_pace;
    logic              hold_req;
    int                hold_left;

    // Line state of the parser model.
    hslp_pkg::t_phase ph;
    logic [13:0]      seen_count;
    logic [2:0]       prefix_hits;
    logic             broken;
    logic             status_line;
    logic [3:0]       ver_major;
    logic [3:0]       ver_minor;
    logic [9:0]       status_val;
    logic [13:0]      method_len;
    logic [12:0]      field_start;
    logic [13:0]      field_len;

    // Line under construction by the stimulus.
    logic [7:0] line_buf[$];
    t_pace      gen_pace;
    logic       gen_drain;
    logic       gen_hold;

    http_start_line_parser_unit #(
        .MAX_LINE (LINE_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic logic in_set(logic [7:0] c, string s);
        for (int i = 0; i < s.len(); i++) begin
            if (c == s[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= hslp_pkg::CH_ZERO && c <= hslp_pkg::CH_NINE;
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_tchar(logic [7:0] c);
        return is_alnum(c) || in_set(c, token_punct) || c == CH_GRAVE;
    endfunction

    function automatic logic is_target(logic [7:0] c);
        return is_alnum(c) || in_set(c, target_punct);
    endfunction

    function automatic logic is_text(logic [7:0] c);
        return c == hslp_pkg::CH_TAB || c == hslp_pkg::CH_SP
            || (c > hslp_pkg::CH_SP && c < hslp_pkg::CH_DEL) || c > hslp_pkg::CH_DEL;
    endfunction

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_line();
        ph          = hslp_pkg::PH_START;
        seen_count  = '0;
        prefix_hits = '0;
        broken      = 1'b0;
        status_line = 1'b0;
        ver_major   = '0;
        ver_minor   = '0;
        status_val  = '0;
        method_len  = '0;
        field_start = '0;
        field_len   = '0;
    endfunction

    function automatic logic [7:0] http_letter(logic [2:0] idx);
        case (idx)
            3'd0:       return hslp_pkg::CH_H;
            3'd1, 3'd2: return hslp_pkg::CH_T;
            default:    return hslp_pkg::CH_P;
        endcase
    endfunction

    // Follows how far the method so far spells the word HTTP.
    function automatic void track_prefix(logic [7:0] c);
        if (prefix_hits < hslp_pkg::PREFIX_FULL && c == http_letter(prefix_hits)) begin
            prefix_hits++;
        end else begin
            prefix_hits = hslp_pkg::PREFIX_MISS;
        end
    endfunction

    function automatic void take_if(logic [7:0] c, logic [7:0] want, hslp_pkg::t_phase nxt);
        if (c == want) ph = nxt;
        else broken = 1'b1;
    endfunction

    function automatic void advance_phase(logic [7:0] c, logic [13:0] at);
        case (ph)
            hslp_pkg::PH_START: begin
                if (!is_tchar(c)) begin
                    broken = 1'b1;
                end else begin
                    track_prefix(c);
                    method_len = 14'd1;
                    ph = hslp_pkg::PH_METHOD;
                end
            end
            hslp_pkg::PH_METHOD: begin
                if (c == hslp_pkg::CH_SP) begin
                    ph = hslp_pkg::PH_TFIRST;
                end else if (c == hslp_pkg::CH_SLASH
                             && prefix_hits == hslp_pkg::PREFIX_FULL) begin
                    status_line = 1'b1;
                    ph = hslp_pkg::PH_VMAJ;
                end else if (is_tchar(c)) begin
                    track_prefix(c);
                    method_len++;
                end else begin
                    broken = 1'b1;
                end
            end
            hslp_pkg::PH_TFIRST: begin
                if (!is_target(c)) begin
                    broken = 1'b1;
                end else begin
                    field_start = at[12:0];
                    field_len = 14'd1;
                    ph = hslp_pkg::PH_TARGET;
                end
            end
            hslp_pkg::PH_TARGET: begin
                if (c == hslp_pkg::CH_SP) ph = hslp_pkg::PH_VH;
                else if (is_target(c)) field_len++;
                else broken = 1'b1;
            end
            hslp_pkg::PH_VH:  take_if(c, hslp_pkg::CH_H, hslp_pkg::PH_VT1);
            hslp_pkg::PH_VT1: take_if(c, hslp_pkg::CH_T, hslp_pkg::PH_VT2);
            hslp_pkg::PH_VT2: take_if(c, hslp_pkg::CH_T, hslp_pkg::PH_VP);
            hslp_pkg::PH_VP:  take_if(c, hslp_pkg::CH_P, hslp_pkg::PH_VSL);
            hslp_pkg::PH_VSL: take_if(c, hslp_pkg::CH_SLASH, hslp_pkg::PH_VMAJ);
            hslp_pkg::PH_VMAJ: begin
                if (!is_digit(c)) begin
                    broken = 1'b1;
                end else begin
                    ver_major = 4'(c - hslp_pkg::CH_ZERO);
                    ph = hslp_pkg::PH_VDOT;
                end
            end
            hslp_pkg::PH_VDOT: take_if(c, hslp_pkg::CH_DOT, hslp_pkg::PH_VMIN);
            hslp_pkg::PH_VMIN: begin
                if (!is_digit(c)) begin
                    broken = 1'b1;
                end else begin
                    ver_minor = 4'(c - hslp_pkg::CH_ZERO);
                    ph = hslp_pkg::PH_VEND;
                end
            end
            hslp_pkg::PH_VEND: begin
                if (status_line) take_if(c, hslp_pkg::CH_SP, hslp_pkg::PH_S1);
                else take_if(c, hslp_pkg::CH_CR, hslp_pkg::PH_LF);
            end
            hslp_pkg::PH_S1, hslp_pkg::PH_S2, hslp_pkg::PH_S3: begin
                if (!is_digit(c)) begin
                    broken = 1'b1;
                end else begin
                    status_val = 10'(status_val * 10 + (c - hslp_pkg::CH_ZERO));
                    ph = (ph == hslp_pkg::PH_S1) ? hslp_pkg::PH_S2 :
                         (ph == hslp_pkg::PH_S2) ? hslp_pkg::PH_S3 : hslp_pkg::PH_SSP;
                end
            end
            hslp_pkg::PH_SSP: begin
                if (c != hslp_pkg::CH_SP) begin
                    broken = 1'b1;
                end else begin
                    field_start = 13'(at + 1);
                    field_len = '0;
                    ph = hslp_pkg::PH_TEXT;
                end
            end
            hslp_pkg::PH_TEXT: begin
                if (c == hslp_pkg::CH_CR) ph = hslp_pkg::PH_LF;
                else if (is_text(c)) field_len++;
                else broken = 1'b1;
            end
            hslp_pkg::PH_LF: take_if(c, hslp_pkg::CH_LF, hslp_pkg::PH_DONE);
            default: broken = 1'b1;
        endcase
    endfunction

    // Runs one accepted byte through the model; a final byte queues a result.
    function automatic void parse_byte(logic [7:0] c, logic fin);
        logic [13:0]       at;
        hslp_pkg::t_result r;
        at = seen_count;
        if (at >= LINE_LIMIT) broken = 1'b1;
        else if (!broken) advance_phase(c, at);
        if (at < LINE_LIMIT) seen_count = 14'(at + 1);
        if (fin) begin
            r = '0;
            if (!broken && ph == hslp_pkg::PH_DONE) begin
                r.line_ok       = 1'b1;
                r.is_response   = status_line;
                r.version_major = ver_major;
                r.version_minor = ver_minor;
                if (status_line) begin
                    r.status_code = status_val;
                    r.text_offset = field_start;
                    r.text_length = field_len;
                end else begin
                    r.method_length = method_len;
                    r.target_offset = field_start;
                    r.target_length = field_len;
                end
            end
            results_due.push_back(r);
            clear_line();
        end
    endfunction

    // ------------------------------------------------------------------
    // Line construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] token_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return pick(alnum_set);
        if (r < 9) return pick(token_punct);
        return CH_GRAVE;
    endfunction

    function automatic logic [7:0] target_byte();
        if ($urandom_range(0, 9) < 6) return pick(alnum_set);
        return pick(target_punct);
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 3))
            0:       return hslp_pkg::CH_TAB;
            1:       return hslp_pkg::CH_SP;
            2:       return 8'($urandom_range(hslp_pkg::CH_SP + 1, hslp_pkg::CH_DEL - 1));
            default: return 8'($urandom_range(hslp_pkg::CH_DEL + 1, 8'hFF));
        endcase
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_version(int maj, int minr);
        put_str("HTTP/");
        line_buf.push_back(8'(hslp_pkg::CH_ZERO + maj));
        line_buf.push_back(hslp_pkg::CH_DOT);
        line_buf.push_back(8'(hslp_pkg::CH_ZERO + minr));
    endfunction

    // An empty method or target string means random characters of the given count.
    function automatic void build_request(string method, int mlen, string target, int tlen,
                                          int maj, int minr);
        if (method.len() != 0) put_str(method);
        else for (int i = 0; i < mlen; i++) line_buf.push_back(token_byte());
        line_buf.push_back(hslp_pkg::CH_SP);
        if (target.len() != 0) put_str(target);
        else for (int i = 0; i < tlen; i++) line_buf.push_back(target_byte());
        line_buf.push_back(hslp_pkg::CH_SP);
        put_version(maj, minr);
        line_buf.push_back(hslp_pkg::CH_CR);
        line_buf.push_back(hslp_pkg::CH_LF);
    endfunction

    function automatic void build_status(int code, int tlen, int maj, int minr);
        put_version(maj, minr);
        line_buf.push_back(hslp_pkg::CH_SP);
        line_buf.push_back(8'(hslp_pkg::CH_ZERO + code / 100));
        line_buf.push_back(8'(hslp_pkg::CH_ZERO + (code / 10) % 10));
        line_buf.push_back(8'(hslp_pkg::CH_ZERO + code % 10));
        line_buf.push_back(hslp_pkg::CH_SP);
        for (int i = 0; i < tlen; i++) line_buf.push_back(text_byte());
        line_buf.push_back(hslp_pkg::CH_CR);
        line_buf.push_back(hslp_pkg::CH_LF);
    endfunction

    function automatic void build_random_line();
        string method;
        string target;
        method = "";
        target = "";
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 19) == 0) method = "HTTP";
            if ($urandom_range(0, 9) == 0) target = "*";
            build_request(method, $urandom_range(1, 6), target, $urandom_range(1, 8),
                          $urandom_range(0, 9), $urandom_range(0, 9));
        end else begin
            build_status($urandom_range(0, 999), $urandom_range(0, 8),
                         $urandom_range(0, 9), $urandom_range(0, 9));
        end
    endfunction

    // Moves the line buffer into the send queue; fin marks its last byte final.
    function automatic void ship_line(logic fin);
        t_tx_item it;
        foreach (line_buf[i]) begin
            it.data  = line_buf[i];
            it.fin   = fin && (i == line_buf.size() - 1);
            it.pace  = gen_pace;
            it.drain = gen_drain && (i == 0);
            it.hold  = gen_hold && (i == 0);
            bytes_to_send.push_back(it);
        end
        if (line_buf.size() != 0) begin
            gen_drain = 1'b0;
            gen_hold  = 1'b0;
        end
        line_buf.delete();
    endfunction

    // ------------------------------------------------------------------
    // Pacing
    // ------------------------------------------------------------------
    function automatic logic send_pauses(t_pace p);
        case (p)
            PACE_SEND_IDLE: return $urandom_range(0, 99) < 88;
            PACE_BOTH:      return $urandom_range(0, 99) < 37;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic logic recv_stalls(t_pace p);
        case (p)
            PACE_RECV_STALL: return $urandom_range(0, 99) < 88;
            PACE_BOTH:       return $urandom_range(0, 99) < 37;
            default:         return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result(hslp_pkg::t_result want, hslp_pkg::t_result got);
        check_field("line_ok", want.line_ok, got.line_ok);
        check_field("is_response", want.is_response, got.is_response);
        check_field("version_major", want.version_major, got.version_major);
        check_field("version_minor", want.version_minor, got.version_minor);
        check_field("status_code", want.status_code, got.status_code);
        check_field("method_length", want.method_length, got.method_length);
        check_field("target_offset", want.target_offset, got.target_offset);
        check_field("target_length", want.target_length, got.target_length);
        check_field("text_offset", want.text_offset, got.text_offset);
        check_field("text_length", want.text_length, got.text_length);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Byte driver: offers the next queued byte and feeds the model on acceptance.
    always @(posedge i_clk) begin : drive_bytes
        t_tx_item head;
        logic     offer;
        logic     start_hold;
        offer = 1'b0;
        start_hold = 1'b0;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.line_byte  <= '0;
            in_ch.final_byte <= 1'b0;
            hold_req         <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                parse_byte(in_ch.line_byte, in_ch.final_byte);
                bytes_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (bytes_to_send.size() != 0) begin
                    head = bytes_to_send[0];
                    // A drain mark holds the byte back until all results are in.
                    offer = !(head.drain && results_due.size() != 0) &&
                            !send_pauses(head.pace);
                end
                if (offer) begin
                    void'(bytes_to_send.pop_front());
                    in_ch.line_byte  <= head.data;
                    in_ch.final_byte <= head.fin;
                    tx_pace          <= head.pace;
                    start_hold = head.hold;
                end
                in_ch.valid <= offer;
            end
            hold_req <= start_hold;
        end
    end

    // Long receiver hold-off, counted down here once requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks each accepted result and paces ready.
    always @(posedge i_clk) begin : watch_results
        hslp_pkg::t_result got;
        hslp_pkg::t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.line_ok       = out_ch.line_ok;
                got.is_response   = out_ch.is_response;
                got.version_major = out_ch.version_major;
                got.version_minor = out_ch.version_minor;
                got.status_code   = out_ch.status_code;
                got.method_length = out_ch.method_length;
                got.target_offset = out_ch.target_offset;
                got.target_length = out_ch.target_length;
                got.text_offset   = out_ch.text_offset;
                got.text_length   = out_ch.text_length;
                if (results_due.size() == 0) begin
                    $display("%0t: result expected none got line_ok %0d", $time,
                             got.line_ok);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    compare_result(want, got);
                end
            end
            out_ch.ready <= (hold_left == 0) && !recv_stalls(tx_pace);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int lines;
        int base;
        int roll;
        int keep;
        int n;

        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.line_byte  = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready     = 1'b0;
        hold_req         = 1'b0;
        hold_left        = 0;
        tx_pace          = PACE_FREE;
        bytes_taken      = 0;
        mismatches       = 0;
        gen_pace         = PACE_FREE;
        gen_drain        = 1'b0;
        gen_hold         = 1'b0;
        clear_line();

        // Directed lines: both forms, digit extremes, the HTTP method and
        // the lone star target, empty reason text.
        build_request("GET", 0, "/", 0, 1, 1);
        ship_line(1'b1);
        build_request("OPTIONS", 0, "*", 0, 0, 9);
        ship_line(1'b1);
        build_request("HTTP", 0, "/x", 0, 9, 0);
        ship_line(1'b1);
        build_request("HTTPS", 0, "", 5, 2, 0);
        ship_line(1'b1);
        build_status(200, 2, 1, 1);
        ship_line(1'b1);
        build_status(999, 0, 2, 0);
        ship_line(1'b1);
        build_status(0, 6, 1, 0);
        ship_line(1'b1);

        // Short and lowercase version prefixes cannot start a status line.
        put_str("HTT/1.1 200 OK");
        line_buf.push_back(hslp_pkg::CH_CR);
        line_buf.push_back(hslp_pkg::CH_LF);
        ship_line(1'b1);
        put_str("http/1.1 200 OK");
        line_buf.push_back(hslp_pkg::CH_CR);
        line_buf.push_back(hslp_pkg::CH_LF);
        ship_line(1'b1);

        // A byte after the closing line feed.
        build_request("GET", 0, "/", 0, 1, 1);
        put_str("X");
        ship_line(1'b1);

        // Final mark in mid line, and a line whose final mark never came.
        put_str("GET /");
        ship_line(1'b1);
        build_request("GET", 0, "/", 0, 1, 1);
        ship_line(1'b0);
        build_request("GET", 0, "/", 0, 1, 1);
        ship_line(1'b1);

        // Bare line feed, and a request without its carriage return.
        line_buf.push_back(hslp_pkg::CH_LF);
        ship_line(1'b1);
        put_str("GET / HTTP/1.1");
        line_buf.push_back(hslp_pkg::CH_LF);
        ship_line(1'b1);

        // Random part, in segments of differing pacing. Each segment starts
        // after a full drain; each free-running one starts with a long
        // receiver hold-off so that the parser backs up.
        lines = 0;
        base = bytes_to_send.size();
        while (bytes_to_send.size() - base < RANDOM_BYTES || lines < RANDOM_LINES) begin
            if (lines % SEGMENT_LINES == 0) begin
                gen_pace  = t_pace'((lines / SEGMENT_LINES) % 4);
                gen_drain = 1'b1;
                gen_hold  = (gen_pace == PACE_FREE);
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                build_random_line();
                ship_line(1'b1);
            end else if (roll < 85) begin
                build_random_line();
                case ($urandom_range(0, 3))
                    0: begin
                        line_buf[$urandom_range(0, line_buf.size() - 1)] =
                            8'($urandom_range(0, 255));
                        ship_line(1'b1);
                    end
                    1: begin
                        keep = $urandom_range(1, line_buf.size() - 1);
                        while (line_buf.size() > keep) void'(line_buf.pop_back());
                        ship_line(1'b1);
                    end
                    2: begin
                        line_buf.push_back(8'($urandom_range(0, 255)));
                        ship_line(1'b1);
                    end
                    default: ship_line(1'b0);
                endcase
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(0, 255)));
                ship_line(1'b1);
            end
            lines++;
        end
        bytes_total = bytes_to_send.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(bytes_taken == bytes_total && results_due.size() == 0)) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
